[hdl/ple_pkg.sv]
// Package for the positional list engine: request/response words and codes.
// No dependencies; used by ple_cell and positional_list_engine_core.
package ple_pkg;

  // request codes
  localparam logic [2:0] REQ_APPEND = 3'd0;
  localparam logic [2:0] REQ_INSERT = 3'd1;
  localparam logic [2:0] REQ_UPDATE = 3'd2;
  localparam logic [2:0] REQ_DELETE = 3'd3;
  localparam logic [2:0] REQ_READ   = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_LOW   = 3'd2;
  localparam logic [2:0] ST_PAST  = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [7:0]         position;
    logic signed [31:0] data_value;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] value_out;
    logic [5:0]         list_length;
  } rsp_t;

  // what every cell of the row does
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_INSERT,
    CELL_UPDATE,
    CELL_DELETE
  } cell_op_e;

  typedef struct packed {
    cell_op_e    op;
    logic [31:0] data;
  } cell_ctl_t;

endpackage

[hdl/ple_cell.sv]
// One list slot of the cell row: holds one element, takes from a neighbor on shift.
// Depends on ple_pkg.
module ple_cell #(
  parameter int CntW = 6,
  parameter int IDX  = 0
) (
  input  logic               clk_i,
  input  ple_pkg::cell_ctl_t ctl_i,
  input  logic [CntW-1:0]    at_i,
  input  logic [CntW-1:0]    cnt_i,
  input  logic [31:0]        prev_i,
  input  logic [31:0]        next_i,
  output logic [31:0]        val_o,
  output logic [31:0]        hit_o
);
  import ple_pkg::*;

  localparam logic [CntW-1:0] MyIdx   = CntW'(IDX);
  localparam logic [CntW-1:0] NextIdx = CntW'(IDX + 1);

  logic [31:0] val_d, val_q;

  always_comb begin
    val_d = val_q;
    case (ctl_i.op)
      CELL_APPEND: begin
        if (cnt_i == MyIdx) val_d = ctl_i.data;
      end
      CELL_INSERT: begin
        if (MyIdx == at_i) begin
          val_d = ctl_i.data;
        end else if (MyIdx > at_i && MyIdx <= cnt_i) begin
          val_d = prev_i;
        end
      end
      CELL_UPDATE: begin
        if (MyIdx == at_i) val_d = ctl_i.data;
      end
      CELL_DELETE: begin
        if (MyIdx >= at_i && NextIdx < cnt_i) val_d = next_i;
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign hit_o = (MyIdx == at_i) ? val_q : 32'd0;

endmodule

[hdl/positional_list_engine_core.sv]
// Positional list engine: a row of CAPACITY cells holding the list, shifting on insert/delete.
// Response: the request is registered into req_q, executed once the output register is free,
//   and its response word is registered into out_q. Throughput: one request word per cycle
//   while the response side keeps up; the whole row shifts at once, so no operation iterates.
// Reset: length clears to zero, no words in flight; cell contents are not reset.
// Depends on ple_pkg and ple_cell.
module positional_list_engine_core #(
  parameter int CAPACITY = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ple_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ple_pkg::rsp_t out_data_o
);
  import ple_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int CmpW = ((CntW > 8) ? CntW : 8) + 1;

  req_t            req_q;
  logic            busy_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  rsp_t            out_q, out_d;
  logic            out_vld_q;

  logic            exec;
  logic [CmpW-1:0] pos_w, n_w, at_w;
  logic [CntW-1:0] at;
  cell_ctl_t       ctl;
  logic [2:0]      status;
  logic            is_full;

  logic [31:0] vals [CAPACITY];
  logic [31:0] hits [CAPACITY];
  logic [31:0] sel_val;

  assign exec       = busy_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !busy_q || exec;

  assign pos_w   = CmpW'(req_q.position);
  assign n_w     = CmpW'(cnt_q);
  assign at_w    = pos_w - CmpW'(1);
  assign at      = CntW'(at_w);
  assign is_full = (cnt_q == CntW'(CAPACITY));

  always_comb begin
    status   = ST_OK;
    ctl.op   = CELL_HOLD;
    ctl.data = req_q.data_value;
    cnt_d    = cnt_q;
    case (req_q.req_type)
      REQ_APPEND: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          ctl.op = CELL_APPEND;
          cnt_d  = cnt_q + CntW'(1);
        end
      end
      REQ_INSERT: begin
        if (cnt_q == '0) begin
          status = ST_EMPTY;
        end else if (pos_w == '0) begin
          status = ST_LOW;
        end else if (pos_w > n_w + CmpW'(1)) begin
          status = ST_PAST;
        end else if (is_full) begin
          status = ST_FULL;
        end else begin
          ctl.op = CELL_INSERT;
          cnt_d  = cnt_q + CntW'(1);
        end
      end
      REQ_UPDATE, REQ_DELETE, REQ_READ: begin
        if (cnt_q == '0) begin
          status = ST_EMPTY;
        end else if (pos_w == '0) begin
          status = ST_LOW;
        end else if (pos_w > n_w) begin
          status = ST_PAST;
        end else if (req_q.req_type == REQ_UPDATE) begin
          ctl.op = CELL_UPDATE;
        end else if (req_q.req_type == REQ_DELETE) begin
          ctl.op = CELL_DELETE;
          cnt_d  = cnt_q - CntW'(1);
        end
      end
      default: status = ST_OK;
    endcase
    if (!exec) begin
      ctl.op = CELL_HOLD;
      cnt_d  = cnt_q;
    end
  end

  // row of cells; each hands its word to its neighbors, the end cells see zero beyond the row
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [31:0] prev_w, next_w;
    if (g == 0) begin : g_first
      assign prev_w = 32'd0;
    end else begin : g_mid_p
      assign prev_w = vals[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_w = 32'd0;
    end else begin : g_mid_n
      assign next_w = vals[g+1];
    end
    ple_cell #(
      .CntW (CntW),
      .IDX  (g)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .at_i   (at),
      .cnt_i  (cnt_q),
      .prev_i (prev_w),
      .next_i (next_w),
      .val_o  (vals[g]),
      .hit_o  (hits[g])
    );
  end

  // only the addressed cell can drive a nonzero hit word
  always_comb begin
    sel_val = 32'd0;
    for (int k = 0; k < CAPACITY; k++) begin
      sel_val = sel_val | hits[k];
    end
  end

  always_comb begin
    out_d.status      = status;
    out_d.value_out   = 32'd0;
    out_d.list_length = 6'(cnt_d);
    if (status == ST_OK &&
        (req_q.req_type == REQ_DELETE || req_q.req_type == REQ_READ)) begin
      out_d.value_out = sel_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (in_valid_i && in_ready_o) begin
        busy_q <= 1'b1;
      end else if (exec) begin
        busy_q <= 1'b0;
      end
      if (exec) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) req_q <= in_data_i;
    if (exec) out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
